### hw/rtl/prelu_pkg.sv
// Shared constants, command codes and register indexes of the PReLU engine.
package prelu_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_CHANNELS_DEF = 64;
    localparam int DATA_WIDTH_DEF   = 16;
    localparam int ACC_WIDTH_DEF    = 48;

    // Fixed field widths.
    localparam int CMD_W      = 3;
    localparam int SEL_W      = 6;
    localparam int SLOPE_W    = 16;
    localparam int SLOPE_FRAC = 12;
    localparam int SPATIAL_W  = 16;
    localparam int CHAN_CNT_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FWD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BWD   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SPATIAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHARED   = 2'd2;

endpackage

### hw/rtl/prelu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module prelu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/prelu_forward_backward.sv
// Top level of the PReLU forward/backward engine with slope-gradient accumulators.
//
// Usage: commands arrive on the slave stream, one per beat, with the command code
// in s_axis_tuser. Forward and backward beats walk a channel-major tensor; the
// block tracks the plane and channel position itself. Every accepted beat gives
// exactly one result beat on the master stream, in order.
// Configuration (spatial size, channel count, shared slope) is written through
// the cfg channel while no command is in flight; cfg_ready is always high.
// Path: an accepted beat passes the stage 1 and stage 2 registers and is then
// registered in the output stage, which drives m_axis_tvalid.
// Throughput: one beat per cycle when not stalled, set by the three-stage pipeline
// (slope RAM read and multiply, accumulator RAM read and add, output register).
// Stalls: each stage holds its beat while the next is full; empty stages keep
// filling, so up to three beats are held before s_axis_tready falls.
// Reset: configuration returns to spatial size 1, one channel, no sharing; both
// position counters and all accumulators read as zero. Slope entries hold no
// value until a load command writes them.
module prelu_forward_backward #(
    parameter int MAX_CHANNELS      = prelu_pkg::MAX_CHANNELS_DEF,
    parameter int DATA_WIDTH        = prelu_pkg::DATA_WIDTH_DEF,
    parameter int ACCUMULATOR_WIDTH = prelu_pkg::ACC_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,

    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // From bit 0: sample_value, upstream_grad, channel_select, slope_word, zero fill.
    input  logic [((2*DATA_WIDTH+prelu_pkg::SEL_W+prelu_pkg::SLOPE_W+7)/8)*8-1:0] s_axis_tdata,
    // From bit 0: cmd.
    input  logic [prelu_pkg::CMD_W-1:0] s_axis_tuser,

    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // From bit 0: result_value, slope_gradient, item_channel, zero fill.
    output logic [((DATA_WIDTH+ACCUMULATOR_WIDTH+prelu_pkg::SEL_W+7)/8)*8-1:0] m_axis_tdata,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [prelu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [prelu_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int DW      = DATA_WIDTH;
    localparam int ACC_W   = ACCUMULATOR_WIDTH;
    localparam int SEL_W   = prelu_pkg::SEL_W;
    localparam int SL_W    = prelu_pkg::SLOPE_W;
    localparam int CP_W    = prelu_pkg::CHAN_CNT_W;
    localparam int SP_W    = prelu_pkg::SPATIAL_W;
    localparam int IDX_W   = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
    localparam int CMP_W   = (IDX_W > CP_W ? IDX_W : CP_W) + 1;
    localparam int PA_W    = DW + SL_W;
    localparam int PB_W    = 2 * DW;
    localparam int SUM_W   = (ACC_W > PB_W ? ACC_W : PB_W) + 1;
    localparam int OUT_W   = ((DW + ACC_W + SEL_W + 7) / 8) * 8;

    localparam logic [CMP_W-1:0]  MAX_C      = CMP_W'(MAX_CHANNELS);
    localparam logic signed [PA_W:0] ROUND_HALF = (PA_W + 1)'(1) << (prelu_pkg::SLOPE_FRAC - 1);
    localparam logic signed [DW-1:0] D_MAX    = {1'b0, {(DW - 1){1'b1}}};
    localparam logic signed [DW-1:0] D_MIN    = {1'b1, {(DW - 1){1'b0}}};
    localparam logic signed [ACC_W-1:0] A_MAX  = {1'b0, {(ACC_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] A_MIN  = {1'b1, {(ACC_W - 1){1'b0}}};

    // Input beat fields.
    logic [prelu_pkg::CMD_W-1:0] in_cmd;
    logic signed [DW-1:0]        in_x;
    logic signed [DW-1:0]        in_g;
    logic [SEL_W-1:0]            in_sel;
    logic signed [SL_W-1:0]      in_slope;

    assign in_cmd   = s_axis_tuser;
    assign in_x     = s_axis_tdata[DW-1:0];
    assign in_g     = s_axis_tdata[2*DW-1:DW];
    assign in_sel   = s_axis_tdata[2*DW+SEL_W-1:2*DW];
    assign in_slope = s_axis_tdata[2*DW+SEL_W+SL_W-1:2*DW+SEL_W];

    // Configuration and position state.
    logic [SP_W-1:0] spatial_reg;
    logic [CP_W-1:0] chan_cnt_reg;
    logic            shared_reg;
    logic [SP_W-1:0] plane_pos_reg;
    logic [CP_W-1:0] chan_pos_reg;
    logic [SP_W-1:0] plane_pos_next;
    logic [CP_W-1:0] chan_pos_next;

    // Pipeline control.
    logic v1_reg, v2_reg, ov_reg;
    logic adv_out, adv2, adv1, fire;

    // Stage 1 payload.
    logic [prelu_pkg::CMD_W-1:0] cmd1_reg;
    logic signed [DW-1:0]        x1_reg;
    logic signed [DW-1:0]        g1_reg;
    logic [IDX_W-1:0]            e1_reg;
    logic                        ok1_reg;
    logic [SEL_W-1:0]            ch1_reg;

    // Stage 2 payload.
    logic [prelu_pkg::CMD_W-1:0] cmd2_reg;
    logic                        xpos2_reg;
    logic signed [DW-1:0]        pass2_reg;
    logic signed [PA_W-1:0]      pa2_reg;
    logic signed [PB_W-1:0]      pb2_reg;
    logic [IDX_W-1:0]            e2_reg;
    logic                        ok2_reg;
    logic [SEL_W-1:0]            ch2_reg;
    logic                        byp2_reg;
    logic signed [ACC_W-1:0]     bypd2_reg;
    logic                        vld2_reg;

    // Output stage.
    logic signed [DW-1:0]    res_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [SEL_W-1:0]        ch_reg;

    logic [MAX_CHANNELS-1:0] acc_valid_reg;

    // Stage 0 decode.
    logic [CMP_W-1:0] sel_ext, pos_ext, e_wide, cnt_ext, chans_eff, chan_inc;
    logic [SP_W:0]    plane_eff, plane_inc;
    logic [IDX_W-1:0] e0;
    logic             ok0;
    logic [SEL_W-1:0] ch0;

    // Stage 1 and 2 datapath.
    logic signed [SL_W-1:0]  slope_rdata;
    logic signed [ACC_W-1:0] acc_rdata;
    logic signed [DW-1:0]    pass1;
    logic                    xpos1;
    logic signed [PA_W:0]    round_sum, round_shift;
    logic signed [DW-1:0]    scaled;
    logic signed [ACC_W-1:0] acc_old, acc_new;
    logic signed [SUM_W-1:0] acc_sum;
    logic signed [DW-1:0]    res_next;
    logic signed [ACC_W-1:0] acc_next;
    logic                    wr_now, clear_now, update2;

    assign cfg_ready = 1'b1;

    assign adv_out       = !ov_reg || m_axis_tready;
    assign adv2          = !v2_reg || adv_out;
    assign adv1          = !v1_reg || adv2;
    assign s_axis_tready = adv1;
    assign fire          = s_axis_tvalid && adv1;

    always_comb
    begin
        sel_ext = CMP_W'(in_sel);
        pos_ext = CMP_W'(chan_pos_reg);
        e_wide  = '0;
        ok0     = 1'b0;
        ch0     = '0;
        if (in_cmd inside {prelu_pkg::CMD_LOAD, prelu_pkg::CMD_READ})
        begin
            e_wide = shared_reg ? '0 : sel_ext;
            ok0    = (e_wide < MAX_C);
            ch0    = in_sel;
        end
        else if (in_cmd inside {prelu_pkg::CMD_FWD, prelu_pkg::CMD_BWD})
        begin
            if (!shared_reg && (pos_ext < MAX_C))
            begin
                e_wide = pos_ext;
            end
            ok0 = 1'b1;
            ch0 = chan_pos_reg[SEL_W-1:0];
        end
        e0 = e_wide[IDX_W-1:0];
    end

    // Position counters after one element.
    always_comb
    begin
        plane_eff = (spatial_reg == '0) ? (SP_W + 1)'(1) : (SP_W + 1)'(spatial_reg);
        plane_inc = (SP_W + 1)'(plane_pos_reg) + (SP_W + 1)'(1);
        cnt_ext   = CMP_W'(chan_cnt_reg);
        if (cnt_ext == '0)
        begin
            chans_eff = CMP_W'(1);
        end
        else if (cnt_ext > MAX_C)
        begin
            chans_eff = MAX_C;
        end
        else
        begin
            chans_eff = cnt_ext;
        end
        chan_inc = pos_ext + CMP_W'(1);
        if (plane_inc >= plane_eff)
        begin
            plane_pos_next = '0;
            chan_pos_next  = (chan_inc >= chans_eff) ? '0 : chan_inc[CP_W-1:0];
        end
        else
        begin
            plane_pos_next = plane_inc[SP_W-1:0];
            chan_pos_next  = chan_pos_reg;
        end
    end

    prelu_ram #(
        .WIDTH (SL_W),
        .DEPTH (MAX_CHANNELS)
    ) u_slope_ram (
        .clk   (clk),
        .we    (fire && (in_cmd == prelu_pkg::CMD_LOAD) && ok0),
        .waddr (e0),
        .wdata (in_slope),
        .re    (fire && (in_cmd inside {prelu_pkg::CMD_FWD, prelu_pkg::CMD_BWD})),
        .raddr (e0),
        .rdata (slope_rdata)
    );

    // Stage 1: one operand feeds both the pass-through and the slope product.
    assign pass1 = (cmd1_reg == prelu_pkg::CMD_FWD) ? x1_reg : g1_reg;
    assign xpos1 = !x1_reg[DW-1] && (x1_reg != '0);

    assign clear_now = v2_reg && adv_out && (cmd2_reg == prelu_pkg::CMD_CLEAR);
    assign update2   = (cmd2_reg == prelu_pkg::CMD_BWD) && !xpos2_reg;
    assign wr_now    = v2_reg && adv_out && update2;

    prelu_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_CHANNELS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (wr_now),
        .waddr (e2_reg),
        .wdata (acc_new),
        .re    (v1_reg && adv2),
        .raddr (e1_reg),
        .rdata (acc_rdata)
    );

    // Stage 2: rounding of the slope product and the saturating accumulate.
    always_comb
    begin
        round_sum   = {pa2_reg[PA_W-1], pa2_reg} + ROUND_HALF;
        round_shift = round_sum >>> prelu_pkg::SLOPE_FRAC;
        if ((&round_shift[PA_W:DW-1]) || !(|round_shift[PA_W:DW-1]))
        begin
            scaled = round_shift[DW-1:0];
        end
        else
        begin
            scaled = round_shift[PA_W] ? D_MIN : D_MAX;
        end

        // A write or clear on the edge of the RAM read is caught by the bypass.
        if (byp2_reg)
        begin
            acc_old = bypd2_reg;
        end
        else
        begin
            acc_old = vld2_reg ? acc_rdata : '0;
        end

        acc_sum = {{(SUM_W - ACC_W){acc_old[ACC_W-1]}}, acc_old}
                + {{(SUM_W - PB_W){pb2_reg[PB_W-1]}}, pb2_reg};
        if ((&acc_sum[SUM_W-1:ACC_W-1]) || !(|acc_sum[SUM_W-1:ACC_W-1]))
        begin
            acc_new = acc_sum[ACC_W-1:0];
        end
        else
        begin
            acc_new = acc_sum[SUM_W-1] ? A_MIN : A_MAX;
        end

        res_next = '0;
        acc_next = '0;
        case (cmd2_reg)
            prelu_pkg::CMD_LOAD, prelu_pkg::CMD_READ:
            begin
                acc_next = ok2_reg ? acc_old : '0;
            end
            prelu_pkg::CMD_FWD:
            begin
                res_next = xpos2_reg ? pass2_reg : scaled;
                acc_next = acc_old;
            end
            prelu_pkg::CMD_BWD:
            begin
                res_next = xpos2_reg ? pass2_reg : scaled;
                acc_next = update2 ? acc_new : acc_old;
            end
            default:
            begin
                res_next = '0;
                acc_next = '0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spatial_reg   <= SP_W'(1);
            chan_cnt_reg  <= CP_W'(1);
            shared_reg    <= 1'b0;
            plane_pos_reg <= '0;
            chan_pos_reg  <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            ov_reg        <= 1'b0;
            acc_valid_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    prelu_pkg::REG_SPATIAL:  spatial_reg  <= cfg_data[SP_W-1:0];
                    prelu_pkg::REG_CHANNELS: chan_cnt_reg <= cfg_data[CP_W-1:0];
                    prelu_pkg::REG_SHARED:   shared_reg   <= cfg_data[0];
                    default:                 ;
                endcase
            end

            if (fire)
            begin
                if (in_cmd inside {prelu_pkg::CMD_FWD, prelu_pkg::CMD_BWD})
                begin
                    plane_pos_reg <= plane_pos_next;
                    chan_pos_reg  <= chan_pos_next;
                end
                else if (in_cmd == prelu_pkg::CMD_CLEAR)
                begin
                    plane_pos_reg <= '0;
                    chan_pos_reg  <= '0;
                end
            end

            if (adv1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv_out)
            begin
                ov_reg <= v2_reg;
            end

            if (clear_now)
            begin
                acc_valid_reg <= '0;
            end
            else if (wr_now)
            begin
                acc_valid_reg[e2_reg] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            cmd1_reg <= in_cmd;
            x1_reg   <= in_x;
            g1_reg   <= in_g;
            e1_reg   <= e0;
            ok1_reg  <= ok0;
            ch1_reg  <= ch0;
        end

        if (v1_reg && adv2)
        begin
            cmd2_reg  <= cmd1_reg;
            xpos2_reg <= xpos1;
            pass2_reg <= pass1;
            pa2_reg   <= pass1 * slope_rdata;
            pb2_reg   <= g1_reg * x1_reg;
            e2_reg    <= e1_reg;
            ok2_reg   <= ok1_reg;
            ch2_reg   <= ch1_reg;
            vld2_reg  <= acc_valid_reg[e1_reg];
            byp2_reg  <= clear_now || (wr_now && (e2_reg == e1_reg));
            bypd2_reg <= clear_now ? '0 : acc_new;
        end

        if (v2_reg && adv_out)
        begin
            res_reg <= res_next;
            acc_reg <= acc_next;
            ch_reg  <= ch2_reg;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = OUT_W'({ch_reg, acc_reg, res_reg});

endmodule

### tb/prelu_forward_backward_tb.sv
// Self-checking testbench for the PReLU forward/backward engine with slope-gradient accumulators.
`timescale 1ns / 100ps

module prelu_forward_backward_tb;

    localparam int DATA_WIDTH_DEF = prelu_pkg::DATA_WIDTH_DEF;
    localparam int ACC_WIDTH_DEF  = prelu_pkg::ACC_WIDTH_DEF;
    localparam int SEL_W          = prelu_pkg::SEL_W;
    localparam int SLOPE_W        = prelu_pkg::SLOPE_W;
    localparam int SLOPE_FRAC     = prelu_pkg::SLOPE_FRAC;
    localparam int CMD_W          = prelu_pkg::CMD_W;
    localparam int CFG_IDX_W      = prelu_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W     = prelu_pkg::CFG_DATA_W;
    localparam int CHAN_CNT_W     = prelu_pkg::CHAN_CNT_W;

    localparam int IN_W   = ((2*DATA_WIDTH_DEF + SEL_W + SLOPE_W + 7) / 8) * 8;
    localparam int IN_PAD = IN_W - 2*DATA_WIDTH_DEF - SEL_W - SLOPE_W;
    localparam int OUT_W  = ((DATA_WIDTH_DEF + ACC_WIDTH_DEF + SEL_W + 7) / 8) * 8;
    localparam int OUT_PAD = OUT_W - DATA_WIDTH_DEF - ACC_WIDTH_DEF - SEL_W;
    localparam int MAX_CH = prelu_pkg::MAX_CHANNELS_DEF;

    localparam longint DATA_MAX = (longint'(1) << (DATA_WIDTH_DEF - 1)) - 1;
    localparam longint ACC_MAX  = (longint'(1) << (ACC_WIDTH_DEF - 1)) - 1;

    // Codes above CMD_CLEAR have no meaning and must leave the state alone.
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = prelu_pkg::CMD_CLEAR + 1'b1;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [IN_PAD-1:0]         pad;
        logic [SLOPE_W-1:0]        slope;
        logic [SEL_W-1:0]          sel;
        logic [DATA_WIDTH_DEF-1:0] grad;
        logic [DATA_WIDTH_DEF-1:0] sample;
    } cmd_payload_t;

    typedef struct packed {
        logic [OUT_PAD-1:0]        pad;
        logic [SEL_W-1:0]          channel;
        logic [ACC_WIDTH_DEF-1:0]  grad_acc;
        logic [DATA_WIDTH_DEF-1:0] value;
    } result_t;

    class prelu_scoreboard;
        longint  slope_mem [MAX_CH];
        longint  grad_acc_mem [MAX_CH];
        int      plane_pos;
        int      chan_pos;
        int      plane_len;
        int      chan_len;
        bit      shared_slope;
        result_t expected_q [$];
        int      error_count;
        int      checked_count;
        int      cmd_seen [1 << CMD_W];

        function new();
            foreach (slope_mem[i])
            begin
                slope_mem[i]    = 0;
                grad_acc_mem[i] = 0;
            end
            foreach (cmd_seen[i])
                cmd_seen[i] = 0;
            plane_pos     = 0;
            chan_pos      = 0;
            plane_len     = 1;
            chan_len      = 1;
            shared_slope  = 1'b0;
            error_count   = 0;
            checked_count = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                prelu_pkg::REG_SPATIAL:  plane_len    = data;
                prelu_pkg::REG_CHANNELS: chan_len     = data[CHAN_CNT_W-1:0];
                prelu_pkg::REG_SHARED:   shared_slope = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Q8.8 times Q4.12, rounded half up back to Q8.8 and saturated.
        function longint apply_slope(longint v, longint s);
            longint p;
            p = (v * s + (longint'(1) << (SLOPE_FRAC - 1))) >>> SLOPE_FRAC;
            if (p > DATA_MAX)
                p = DATA_MAX;
            else if (p < -DATA_MAX - 1)
                p = -DATA_MAX - 1;
            return p;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, cmd_payload_t p);
            result_t r;
            int      entry;
            int      plane_lim;
            int      chan_lim;
            longint  x;
            longint  g;
            longint  sum;
            r = '0;
            x = longint'($signed(p.sample));
            g = longint'($signed(p.grad));
            cmd_seen[cmd]++;
            if (cmd == prelu_pkg::CMD_LOAD || cmd == prelu_pkg::CMD_READ)
            begin
                entry     = shared_slope ? 0 : int'(p.sel);
                r.channel = p.sel;
                if (cmd == prelu_pkg::CMD_LOAD)
                    slope_mem[entry] = longint'($signed(p.slope));
                r.grad_acc = ACC_WIDTH_DEF'(grad_acc_mem[entry]);
            end
            else if (cmd == prelu_pkg::CMD_FWD || cmd == prelu_pkg::CMD_BWD)
            begin
                entry     = shared_slope ? 0 : chan_pos;
                r.channel = SEL_W'(chan_pos);
                if (cmd == prelu_pkg::CMD_FWD)
                    r.value = (x > 0) ? p.sample
                                      : DATA_WIDTH_DEF'(apply_slope(x, slope_mem[entry]));
                else if (x > 0)
                    r.value = p.grad;
                else
                begin
                    r.value = DATA_WIDTH_DEF'(apply_slope(g, slope_mem[entry]));
                    sum = grad_acc_mem[entry] + g * x;
                    if (sum > ACC_MAX)
                        sum = ACC_MAX;
                    else if (sum < -ACC_MAX - 1)
                        sum = -ACC_MAX - 1;
                    grad_acc_mem[entry] = sum;
                end
                r.grad_acc = ACC_WIDTH_DEF'(grad_acc_mem[entry]);
                // Sizes of zero act as one, channel counts above the table act as its depth.
                plane_lim = (plane_len == 0) ? 1 : plane_len;
                chan_lim  = (chan_len == 0) ? 1 : ((chan_len > MAX_CH) ? MAX_CH : chan_len);
                plane_pos++;
                if (plane_pos >= plane_lim)
                begin
                    plane_pos = 0;
                    chan_pos++;
                    if (chan_pos >= chan_lim)
                        chan_pos = 0;
                end
            end
            else if (cmd == prelu_pkg::CMD_CLEAR)
            begin
                foreach (grad_acc_mem[i])
                    grad_acc_mem[i] = 0;
                plane_pos = 0;
                chan_pos  = 0;
            end
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
            error_count++;
            $display("ERROR result %0d: %s expected 0x%0h got 0x%0h",
                     checked_count, what, want, got);
        endtask

        task check_result(result_t got);
            result_t want;
            checked_count++;
            if (expected_q.size() == 0)
            begin
                report_mismatch("beat with nothing outstanding, value", 0, got.value);
                return;
            end
            want = expected_q.pop_front();
            if (got.value !== want.value)
                report_mismatch("result_value", want.value, got.value);
            if (got.grad_acc !== want.grad_acc)
                report_mismatch("slope_gradient", want.grad_acc, got.grad_acc);
            if (got.channel !== want.channel)
                report_mismatch("item_channel", want.channel, got.channel);
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    prelu_scoreboard board = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;

    prelu_forward_backward u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Results are checked before the beat accepted at the same edge is predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(result_t'(m_axis_tdata));
            if (s_axis_tvalid && s_axis_tready)
                board.note_command(s_axis_tuser, cmd_payload_t'(s_axis_tdata));
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, board.pending());
            $display("** prelu_forward_backward: FAILED **");
            $finish;
        end
    end

    task automatic push_command(input logic [CMD_W-1:0] cmd, input logic [15:0] x,
                                input logic [15:0] g, input logic [SEL_W-1:0] sel,
                                input logic [15:0] sw);
        cmd_payload_t p;
        p.pad    = '0;
        p.slope  = sw;
        p.sel    = sel;
        p.grad   = g;
        p.sample = x;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Mostly full-range words, with extremes and small magnitudes mixed in.
    function automatic logic [15:0] draw_q_word();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom_range(511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_random_command();
        int               pick;
        logic [CMD_W-1:0] cmd;
        pick = $urandom_range(99);
        if (pick < 38)
            cmd = prelu_pkg::CMD_FWD;
        else if (pick < 78)
            cmd = prelu_pkg::CMD_BWD;
        else if (pick < 86)
            cmd = prelu_pkg::CMD_LOAD;
        else if (pick < 93)
            cmd = prelu_pkg::CMD_READ;
        else if (pick < 95)
            cmd = prelu_pkg::CMD_CLEAR;
        else
            cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        push_command(cmd, draw_q_word(), draw_q_word(), SEL_W'($urandom), draw_q_word());
    endtask

    // Stop sending and wait until every outstanding result beat has arrived.
    // The first edge lets the monitor note a beat accepted at the current edge.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_register(idx, data);
    endtask

    // Unused upper bits of the narrow registers carry random junk.
    task automatic configure(input logic [15:0] spatial, input logic [6:0] chans,
                             input logic shared);
        hold_until_drained();
        write_reg(prelu_pkg::REG_SPATIAL, spatial);
        write_reg(prelu_pkg::REG_CHANNELS, {9'($urandom), chans});
        write_reg(prelu_pkg::REG_SHARED, {15'($urandom), shared});
        cfg_valid <= 1'b0;
    endtask

    // Counters are not cleared between phases, so a smaller setting can start out of bounds.
    task automatic run_phase(input logic [15:0] spatial, input logic [6:0] chans,
                             input logic shared, input int beats);
        configure(spatial, chans, shared);
        for (int n = 0; n < beats; n++)
        begin
            if (n == beats / 2)
                hold_until_drained();
            push_random_command();
        end
    endtask

    initial
    begin
        int unused_total;
        logic [15:0] slope;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 27;
        recv_idle_pct = 45;
        configure(16'd2, 7'd3, 1'b0);

        // Every slope entry gets written before any element can use it.
        for (int i = 0; i < MAX_CH; i++)
        begin
            case (i)
                0: slope = 16'h8000;
                1: slope = 16'h7FFF;
                2: slope = 16'h0000;
                3: slope = 16'h1000;
                default: slope = 16'($urandom);
            endcase
            push_command(prelu_pkg::CMD_LOAD, 16'($urandom), 16'($urandom), SEL_W'(i), slope);
        end

        push_command(prelu_pkg::CMD_FWD, 16'h7FFF, 16'h0000, '0, 16'h0000);
        push_command(prelu_pkg::CMD_FWD, 16'h8000, 16'h0000, '0, 16'h0000);
        push_command(prelu_pkg::CMD_FWD, 16'h0000, 16'h0000, '0, 16'h0000);
        push_command(prelu_pkg::CMD_FWD, 16'hFFFF, 16'h0000, '0, 16'h0000);
        push_command(prelu_pkg::CMD_BWD, 16'h8000, 16'h8000, '0, 16'h0000);
        push_command(prelu_pkg::CMD_BWD, 16'h0001, 16'h7FFF, '0, 16'h0000);
        push_command(prelu_pkg::CMD_BWD, 16'h8000, 16'h7FFF, '0, 16'h0000);
        push_command(prelu_pkg::CMD_BWD, 16'h0000, 16'h7FFF, '0, 16'h0000);
        push_command(prelu_pkg::CMD_READ, 16'h0000, 16'h0000, 6'd0, 16'h0000);
        push_command(prelu_pkg::CMD_READ, 16'hFFFF, 16'hFFFF, 6'd2, 16'hFFFF);
        push_command(prelu_pkg::CMD_READ, 16'h0000, 16'h0000, '1, 16'h0000);
        push_command(prelu_pkg::CMD_LOAD, 16'h0000, 16'h0000, 6'd3, 16'h1000);
        for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
            push_command(CMD_W'(c), 16'($urandom), 16'($urandom), SEL_W'($urandom),
                         16'($urandom));
        push_command(prelu_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), SEL_W'($urandom),
                     16'($urandom));
        push_command(prelu_pkg::CMD_READ, 16'h0000, 16'h0000, 6'd2, 16'h0000);

        // Shared slope: loads and reads hit entry 0 while the channel echoes the select.
        configure(16'd1, 7'd4, 1'b1);
        push_command(prelu_pkg::CMD_LOAD, 16'h0000, 16'h0000, 6'd40, 16'hF000);
        push_command(prelu_pkg::CMD_READ, 16'h0000, 16'h0000, 6'd17, 16'h0000);
        push_command(prelu_pkg::CMD_FWD, 16'h8000, 16'h0000, '0, 16'h0000);
        push_command(prelu_pkg::CMD_BWD, 16'hFF00, 16'h0100, '0, 16'h0000);
        push_command(prelu_pkg::CMD_READ, 16'h0000, 16'h0000, 6'd33, 16'h0000);

        run_phase(16'd3, 7'd4, 1'b0, 250);
        run_phase(16'd1, 7'd64, 1'b0, 300);
        run_phase(16'd5, 7'd2, 1'b0, 200);

        send_idle_pct = 45;
        recv_idle_pct = 27;
        run_phase(16'd0, 7'd0, 1'b1, 100);
        run_phase(16'hFFFF, 7'd127, 1'b0, 150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(16'd7, 7'd1, 1'b0, 250);
        run_phase(16'($urandom_range(1, 9)), 7'($urandom_range(2, 64)), 1'b1, 300);

        hold_until_drained();
        repeat (8) @(posedge clk);
        if (board.pending() != 0)
            board.report_mismatch("results never delivered, count", 0, board.pending());

        unused_total = 0;
        for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
            unused_total += board.cmd_seen[c];
        $display("beats sent: %0d load, %0d forward, %0d backward, %0d read, %0d clear, %0d unused",
                 board.cmd_seen[prelu_pkg::CMD_LOAD], board.cmd_seen[prelu_pkg::CMD_FWD],
                 board.cmd_seen[prelu_pkg::CMD_BWD], board.cmd_seen[prelu_pkg::CMD_READ],
                 board.cmd_seen[prelu_pkg::CMD_CLEAR], unused_total);
        $display("9 register settings incl. zero and oversized counts, %0d results, %0d errors",
                 board.checked_count, board.error_count);
        if (board.error_count == 0)
            $display("** prelu_forward_backward: PASSED **");
        else
            $display("** prelu_forward_backward: FAILED **");
        $finish;
    end

endmodule

### files.f
hw/rtl/prelu_pkg.sv
hw/rtl/prelu_ram.sv
hw/rtl/prelu_forward_backward.sv
tb/prelu_forward_backward_tb.sv
